@@ sv/nlwag_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nlwag_pkg
// Shared types and constants of the nested loop write address generator.
// ============================================================================
package nlwag_pkg;

    // Parameter defaults
    localparam int MEMORY_WORDS_DEF = 2048;
    localparam int DATA_BITS_DEF    = 32;

    // Fixed field widths
    localparam int CNT_W      = 10;  // loop counters, periods, iterations, duty
    localparam int STEP_W     = 11;  // signed increments and shifts
    localparam int DELAY_W    = 8;   // start delay
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INNER_PERIOD     = 3'd0,
        CFG_INNER_ITERATIONS = 3'd1,
        CFG_INNER_INCREMENT  = 3'd2,
        CFG_INNER_SHIFT      = 3'd3,
        CFG_OUTER_PERIOD     = 3'd4,
        CFG_OUTER_ITERATIONS = 3'd5,
        CFG_OUTER_INCREMENT  = 3'd6,
        CFG_OUTER_SHIFT      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        [CNT_W-1:0]  inner_period;
        logic        [CNT_W-1:0]  inner_iterations;
        logic signed [STEP_W-1:0] inner_increment;
        logic signed [STEP_W-1:0] inner_shift;
        logic        [CNT_W-1:0]  outer_period;
        logic        [CNT_W-1:0]  outer_iterations;
        logic signed [STEP_W-1:0] outer_increment;
        logic signed [STEP_W-1:0] outer_shift;
    } t_cfg;

endpackage : nlwag_pkg
`default_nettype wire

@@ sv/nlwag_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nlwag_cfg
// Loop configuration registers, written through the configuration channel.
// ============================================================================
module nlwag_cfg
    import nlwag_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_INNER_PERIOD:     n_cfg.inner_period     = i_cfg_data[CNT_W-1:0];
                CFG_INNER_ITERATIONS: n_cfg.inner_iterations = i_cfg_data[CNT_W-1:0];
                CFG_INNER_INCREMENT:  n_cfg.inner_increment  = $signed(i_cfg_data);
                CFG_INNER_SHIFT:      n_cfg.inner_shift      = $signed(i_cfg_data);
                CFG_OUTER_PERIOD:     n_cfg.outer_period     = i_cfg_data[CNT_W-1:0];
                CFG_OUTER_ITERATIONS: n_cfg.outer_iterations = i_cfg_data[CNT_W-1:0];
                CFG_OUTER_INCREMENT:  n_cfg.outer_increment  = $signed(i_cfg_data);
                CFG_OUTER_SHIFT:      n_cfg.outer_shift      = $signed(i_cfg_data);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule : nlwag_cfg
`default_nettype wire

@@ sv/nlwag_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nlwag_step
// Loop state registers and the one-item step: start, delay countdown and
// the two- or four-level strided loop. The result is combinational.
// ============================================================================
module nlwag_step
    import nlwag_pkg::*;
#(
    parameter int HALF_W    = 10,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic                        i_cmd,
    input  wire logic        [CNT_W-1:0]     i_start_addr,
    input  wire logic        [CNT_W-1:0]     i_duty,
    input  wire logic        [DELAY_W-1:0]   i_delay_cycles,
    input  wire logic signed [DATA_BITS-1:0] i_data_in,
    input  t_cfg                             i_cfg,
    output logic                             o_write_valid,
    output logic             [HALF_W:0]      o_write_addr,
    output logic signed      [DATA_BITS-1:0] o_write_data,
    output logic                             o_run_done
);

    localparam int EXT_W = (HALF_W > STEP_W) ? HALF_W : STEP_W;
    localparam int SA_W  = (HALF_W > CNT_W) ? HALF_W : CNT_W;

    // state
    logic [DELAY_W-1:0] r_delay_left, n_delay_left;
    logic [HALF_W-1:0]  r_cur_addr, n_cur_addr;
    logic [HALF_W-1:0]  r_outer_base, n_outer_base;
    logic [CNT_W-1:0]   r_tick_count, n_tick_count;
    logic [CNT_W-1:0]   r_period_count, n_period_count;
    logic [CNT_W-1:0]   r_outer_tick_count, n_outer_tick_count;
    logic [CNT_W-1:0]   r_outer_count, n_outer_count;
    logic [CNT_W-1:0]   r_duty_count, n_duty_count;
    logic [CNT_W-1:0]   r_active_duty, n_active_duty;
    logic               r_finished, n_finished;
    logic               r_bank, n_bank;

    // steps reduced modulo the bank size (power of two)
    logic [EXT_W-1:0]  inc_ext, shift_ext, oinc_ext, oshift_ext;
    logic [HALF_W-1:0] inc_h, shift_h, oinc_h, oshift_h;
    logic [SA_W-1:0]   sa_ext;

    assign inc_ext    = EXT_W'(i_cfg.inner_increment);
    assign shift_ext  = EXT_W'(i_cfg.inner_shift);
    assign oinc_ext   = EXT_W'(i_cfg.outer_increment);
    assign oshift_ext = EXT_W'(i_cfg.outer_shift);
    assign inc_h      = inc_ext[HALF_W-1:0];
    assign shift_h    = shift_ext[HALF_W-1:0];
    assign oinc_h     = oinc_ext[HALF_W-1:0];
    assign oshift_h   = oshift_ext[HALF_W-1:0];
    assign sa_ext     = SA_W'(i_start_addr);

    // innermost tick, evaluated speculatively
    logic              it_en;
    logic [CNT_W-1:0]  it_tick, it_duty, it_period;
    logic [HALF_W-1:0] it_cur;

    always_comb begin
        it_en     = 1'b0;
        it_tick   = r_tick_count;
        it_duty   = r_duty_count;
        it_period = r_period_count;
        it_cur    = r_cur_addr;
        if (r_tick_count < i_cfg.inner_period) begin
            it_tick = r_tick_count + CNT_W'(1);
            if (r_duty_count < r_active_duty) begin
                it_en   = 1'b1;
                it_duty = r_duty_count + CNT_W'(1);
                it_cur  = r_cur_addr + inc_h;
            end
        end
        if (it_tick == i_cfg.inner_period) begin
            it_tick   = '0;
            it_duty   = '0;
            it_period = r_period_count + CNT_W'(1);
            it_cur    = it_cur + shift_h;
        end
    end

    logic two_level;
    logic en;

    assign two_level = (i_cfg.outer_iterations == '0) && (i_cfg.outer_period == '0);

    always_comb begin
        n_delay_left       = r_delay_left;
        n_cur_addr         = r_cur_addr;
        n_outer_base       = r_outer_base;
        n_tick_count       = r_tick_count;
        n_period_count     = r_period_count;
        n_outer_tick_count = r_outer_tick_count;
        n_outer_count      = r_outer_count;
        n_duty_count       = r_duty_count;
        n_active_duty      = r_active_duty;
        n_finished         = r_finished;
        n_bank             = r_bank;
        en                 = 1'b0;
        if (i_fire) begin
            if (i_cmd == CMD_START) begin
                n_finished         = 1'b0;
                n_cur_addr         = sa_ext[HALF_W-1:0];
                n_outer_base       = sa_ext[HALF_W-1:0];
                n_active_duty      = (i_duty == '0) ? i_cfg.inner_period : i_duty;
                n_delay_left       = i_delay_cycles;
                n_tick_count       = '0;
                n_period_count     = '0;
                n_outer_tick_count = '0;
                n_outer_count      = '0;
                n_duty_count       = '0;
                n_bank             = ~r_bank;
            end else if (r_delay_left != '0) begin
                n_delay_left = r_delay_left - DELAY_W'(1);
            end else if (!r_finished) begin
                if (two_level) begin
                    if (r_period_count < i_cfg.inner_iterations) begin
                        en             = it_en;
                        n_tick_count   = it_tick;
                        n_duty_count   = it_duty;
                        n_period_count = it_period;
                        n_cur_addr     = it_cur;
                    end
                    if (n_period_count == i_cfg.inner_iterations) begin
                        n_period_count = '0;
                        n_finished     = 1'b1;
                    end
                end else begin
                    if (r_outer_count < i_cfg.outer_iterations) begin
                        if (r_outer_tick_count < i_cfg.outer_period) begin
                            if (r_period_count < i_cfg.inner_iterations) begin
                                en             = it_en;
                                n_tick_count   = it_tick;
                                n_duty_count   = it_duty;
                                n_period_count = it_period;
                                n_cur_addr     = it_cur;
                            end
                            // inner nest complete: step the outer base
                            if (n_period_count == i_cfg.inner_iterations) begin
                                n_period_count     = '0;
                                n_outer_base       = r_outer_base + oinc_h;
                                n_cur_addr         = n_outer_base;
                                n_outer_tick_count = r_outer_tick_count + CNT_W'(1);
                            end
                        end
                        // outer period complete: jump the outer base
                        if (n_outer_tick_count == i_cfg.outer_period) begin
                            n_outer_base       = n_outer_base + oshift_h;
                            n_cur_addr         = n_outer_base;
                            n_outer_tick_count = '0;
                            n_outer_count      = r_outer_count + CNT_W'(1);
                        end
                    end
                    if (n_outer_count == i_cfg.outer_iterations) begin
                        n_finished = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_left       <= '0;
            r_cur_addr         <= '0;
            r_outer_base       <= '0;
            r_tick_count       <= '0;
            r_period_count     <= '0;
            r_outer_tick_count <= '0;
            r_outer_count      <= '0;
            r_duty_count       <= '0;
            r_active_duty      <= '0;
            r_finished         <= 1'b1;
            r_bank             <= 1'b0;
        end else begin
            r_delay_left       <= n_delay_left;
            r_cur_addr         <= n_cur_addr;
            r_outer_base       <= n_outer_base;
            r_tick_count       <= n_tick_count;
            r_period_count     <= n_period_count;
            r_outer_tick_count <= n_outer_tick_count;
            r_outer_count      <= n_outer_count;
            r_duty_count       <= n_duty_count;
            r_active_duty      <= n_active_duty;
            r_finished         <= n_finished;
            r_bank             <= n_bank;
        end
    end

    // write address is the address before this tick's update
    assign o_write_valid = en;
    assign o_write_addr  = en ? {r_bank, r_cur_addr} : '0;
    assign o_write_data  = en ? i_data_in : '0;
    assign o_run_done    = n_finished;

    a_delay_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_cmd == CMD_TICK) && (r_delay_left != '0) |-> !o_write_valid)
        else $error("write while start delay running");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_cmd == CMD_TICK) && r_finished |=> r_finished)
        else $error("run done cleared by a tick");

    a_bank_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_cmd == CMD_START) |=> r_bank != $past(r_bank))
        else $error("start did not swap bank");

endmodule : nlwag_step
`default_nettype wire

@@ sv/nested_loop_write_address_generator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nested_loop_write_address_generator_core
// Strided write address generator with ping-pong banks: start items load a
// run, tick items step a two- or four-level loop and emit write requests.
// ============================================================================
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------
//  in       | slave     | i_in_valid / o_in_ready | i_cmd, i_start_addr, i_duty,
//           |           |                         | i_delay_cycles, i_data_in
//  out      | master    | o_out_valid/i_out_ready | o_write_valid, o_write_addr,
//           |           |                         | o_write_data, o_run_done
//  cfg      | slave     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One item per cycle sustained while out is taken; every item's result passes
//  the input register, then the result register, before it is on the outputs.
//  The loop step is a single pass of compares and two short adder chains
//  between the input register and the result register.
//  A stalled output holds the result register; the input register still takes
//  one more item, then in stays not ready until out is taken.
//  Reset (synchronous, active low) clears the valid flags, the loop state and the
//  configuration, and leaves the block idle with run done set; the configuration channel is always ready.
//
module nested_loop_write_address_generator_core
    import nlwag_pkg::*;
#(
    parameter  int MEMORY_WORDS = MEMORY_WORDS_DEF,  // power of two
    parameter  int DATA_BITS    = DATA_BITS_DEF,
    localparam int ADDR_W       = $clog2(MEMORY_WORDS)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // item input
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_cmd,
    input  wire logic        [CNT_W-1:0]     i_start_addr,
    input  wire logic        [CNT_W-1:0]     i_duty,
    input  wire logic        [DELAY_W-1:0]   i_delay_cycles,
    input  wire logic signed [DATA_BITS-1:0] i_data_in,
    // result output
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_write_valid,
    output logic             [ADDR_W-1:0]    o_write_addr,
    output logic signed      [DATA_BITS-1:0] o_write_data,
    output logic                             o_run_done,
    // configuration writes
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic       [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int HALF_W = ADDR_W - 1;  // address bits within one bank

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_cfg cfg;

    nlwag_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Pipeline control: the result register advances when empty or taken;
    // the input register accepts whenever it is empty or moves on.
    // ------------------------------------------------------------------
    logic advance;
    logic fire;
    logic in_acc;

    logic r_in_valid;
    logic r_out_valid;

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;
    assign in_acc     = i_in_valid && o_in_ready;

    // input register
    logic                        r_cmd;
    logic        [CNT_W-1:0]     r_start_addr;
    logic        [CNT_W-1:0]     r_duty;
    logic        [DELAY_W-1:0]   r_delay_cycles;
    logic signed [DATA_BITS-1:0] r_data_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd          <= i_cmd;
            r_start_addr   <= i_start_addr;
            r_duty         <= i_duty;
            r_delay_cycles <= i_delay_cycles;
            r_data_in      <= i_data_in;
        end
    end

    // ------------------------------------------------------------------
    // Loop step (state updates only when the item moves to the result reg)
    // ------------------------------------------------------------------
    logic                        step_write_valid;
    logic [ADDR_W-1:0]           step_write_addr;
    logic signed [DATA_BITS-1:0] step_write_data;
    logic                        step_run_done;

    nlwag_step #(
        .HALF_W    (HALF_W),
        .DATA_BITS (DATA_BITS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_cmd          (r_cmd),
        .i_start_addr   (r_start_addr),
        .i_duty         (r_duty),
        .i_delay_cycles (r_delay_cycles),
        .i_data_in      (r_data_in),
        .i_cfg          (cfg),
        .o_write_valid  (step_write_valid),
        .o_write_addr   (step_write_addr),
        .o_write_data   (step_write_data),
        .o_run_done     (step_run_done)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                        r_write_valid;
    logic [ADDR_W-1:0]           r_write_addr;
    logic signed [DATA_BITS-1:0] r_write_data;
    logic                        r_run_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_write_valid <= step_write_valid;
            r_write_addr  <= step_write_addr;
            r_write_data  <= step_write_data;
            r_run_done    <= step_run_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_write_valid = r_write_valid;
    assign o_write_addr  = r_write_addr;
    assign o_write_data  = r_write_data;
    assign o_run_done    = r_run_done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_valid |-> (o_write_addr == '0) && (o_write_data == '0))
        else $error("non-write result carries address or data");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_cmd == CMD_START) |=> o_out_valid && !o_run_done && !o_write_valid)
        else $error("start item result wrong");

endmodule : nested_loop_write_address_generator_core
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the nested loop write address generator. Start and
// tick items go in over a valid/ready channel, and configuration writes go
// over a channel of their own. A cycle-level predictor of the loop nest and
// the ping-pong bank sits in the bench. It queues one expected write request
// per accepted item, and a monitor compares every result field by field.
// The directed tests come first, then random runs with idle bursts on both
// sides, a long output stall, register extremes, and a final stretch with no idling.
// ============================================================================
module testbench;
    import nlwag_pkg::*;

    localparam int MEM_WORDS   = MEMORY_WORDS_DEF;
    localparam int DATA_W      = DATA_BITS_DEF;
    localparam int ADDR_W      = $clog2(MEM_WORDS);
    localparam int OFS_W       = ADDR_W - 1;          // address inside one bank half
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 4;                   // two-stage pipe plus margin

    typedef struct packed {
        logic               cmd;
        logic [CNT_W-1:0]   start_addr;
        logic [CNT_W-1:0]   duty;
        logic [DELAY_W-1:0] delay;
        logic [DATA_W-1:0]  data;
    } t_gen_item;

    typedef struct packed {
        logic              wr_valid;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              done;
    } t_write_req;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  i_cmd          = CMD_TICK;
    logic [CNT_W-1:0]      i_start_addr   = '0;
    logic [CNT_W-1:0]      i_duty         = '0;
    logic [DELAY_W-1:0]    i_delay_cycles = '0;
    logic [DATA_W-1:0]     i_data_in      = '0;
    logic                  i_out_ready    = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_INNER_PERIOD;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_write_valid;
    logic [ADDR_W-1:0]     o_write_addr;
    logic [DATA_W-1:0]     o_write_data;
    logic                  o_run_done;
    logic                  o_cfg_ready;

    nested_loop_write_address_generator_core #(
        .MEMORY_WORDS (MEM_WORDS),
        .DATA_BITS    (DATA_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_start_addr   (i_start_addr),
        .i_duty         (i_duty),
        .i_delay_cycles (i_delay_cycles),
        .i_data_in      (i_data_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_write_valid  (o_write_valid),
        .o_write_addr   (o_write_addr),
        .o_write_data   (o_write_data),
        .o_run_done     (o_run_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: shadow registers plus the loop nest counters
    // ------------------------------------------------------------------------
    t_cfg               cfg_shadow = '0;
    logic [DELAY_W-1:0] pred_delay = '0;
    logic [OFS_W-1:0]   pred_addr = '0;
    logic [OFS_W-1:0]   pred_base = '0;
    logic [CNT_W-1:0]   pred_tick = '0;
    logic [CNT_W-1:0]   pred_period = '0;
    logic [CNT_W-1:0]   pred_outer_tick = '0;
    logic [CNT_W-1:0]   pred_outer = '0;
    logic [CNT_W-1:0]   pred_duty = '0;
    logic [CNT_W-1:0]   pred_duty_len = '0;
    logic               pred_done = 1'b1;     // idle out of reset
    logic               pred_bank = 1'b0;

    t_write_req pending_writes[$];
    int unsigned error_count = 0;
    bit src_gaps_on = 1'b1;
    bit sink_stalls_on = 1'b1;
    int unsigned sink_hold_req = 0;           // long output stall, in cycles
    int unsigned hold_left = 0;

    // Address steps wrap inside the bank half; only the low bits of the step matter.
    function automatic logic [OFS_W-1:0] bank_step(logic [OFS_W-1:0] a,
                                                   logic signed [STEP_W-1:0] d);
        return a + d[OFS_W-1:0];
    endfunction

    // Innermost level: one tick of the duty-windowed period.
    function automatic logic period_tick(output logic [OFS_W-1:0] wa);
        logic en;
        en = 1'b0;
        wa = '0;
        if (pred_tick < cfg_shadow.inner_period) begin
            pred_tick = pred_tick + 1'b1;
            if (pred_duty < pred_duty_len) begin
                en = 1'b1;
                wa = pred_addr;
                pred_duty = pred_duty + 1'b1;
                pred_addr = bank_step(pred_addr, cfg_shadow.inner_increment);
            end
        end
        if (pred_tick == cfg_shadow.inner_period) begin
            pred_tick = '0;
            pred_duty = '0;
            pred_period = pred_period + 1'b1;
            pred_addr = bank_step(pred_addr, cfg_shadow.inner_shift);
        end
        return en;
    endfunction

    function automatic logic loop_step(output logic [OFS_W-1:0] wa);
        logic en;
        en = 1'b0;
        wa = '0;
        if (cfg_shadow.outer_iterations == 0 && cfg_shadow.outer_period == 0) begin
            // two-level nest
            if (pred_period < cfg_shadow.inner_iterations)
                en = period_tick(wa);
            if (pred_period == cfg_shadow.inner_iterations) begin
                pred_period = '0;
                pred_done = 1'b1;
            end
        end else begin
            if (pred_outer < cfg_shadow.outer_iterations) begin
                if (pred_outer_tick < cfg_shadow.outer_period) begin
                    if (pred_period < cfg_shadow.inner_iterations)
                        en = period_tick(wa);
                    if (pred_period == cfg_shadow.inner_iterations) begin
                        pred_period = '0;
                        pred_base = bank_step(pred_base, cfg_shadow.outer_increment);
                        pred_addr = pred_base;
                        pred_outer_tick = pred_outer_tick + 1'b1;
                    end
                end
                if (pred_outer_tick == cfg_shadow.outer_period) begin
                    pred_base = bank_step(pred_base, cfg_shadow.outer_shift);
                    pred_addr = pred_base;
                    pred_outer_tick = '0;
                    pred_outer = pred_outer + 1'b1;
                end
            end
            if (pred_outer == cfg_shadow.outer_iterations)
                pred_done = 1'b1;
        end
        return en;
    endfunction

    function automatic t_write_req predict_write(t_gen_item it);
        logic             en;
        logic [OFS_W-1:0] wa;
        t_write_req       r;
        en = 1'b0;
        wa = '0;
        if (it.cmd == CMD_START) begin
            pred_done = 1'b0;
            pred_addr = it.start_addr[OFS_W-1:0];
            pred_base = pred_addr;
            pred_duty_len = (it.duty == 0) ? cfg_shadow.inner_period : it.duty;
            pred_delay = it.delay;
            pred_tick = '0;
            pred_period = '0;
            pred_outer_tick = '0;
            pred_outer = '0;
            pred_duty = '0;
            pred_bank = ~pred_bank;
        end else if (pred_delay != 0) begin
            pred_delay = pred_delay - 1'b1;
        end else if (!pred_done) begin
            en = loop_step(wa);
        end
        r.wr_valid = en;
        r.addr = en ? {pred_bank, wa} : '0;
        r.data = en ? it.data : '0;
        r.done = pred_done;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Item builders and channel drivers
    // ------------------------------------------------------------------------
    function automatic t_gen_item tick_item(logic [DATA_W-1:0] word);
        t_gen_item it;
        it.cmd = CMD_TICK;
        it.start_addr = CNT_W'($urandom);     // ignored on ticks, toggled anyway
        it.duty = CNT_W'($urandom);
        it.delay = DELAY_W'($urandom);
        it.data = word;
        return it;
    endfunction

    function automatic t_gen_item start_item(int unsigned sa, int unsigned du, int unsigned dl);
        t_gen_item it;
        it.cmd = CMD_START;
        it.start_addr = CNT_W'(sa);
        it.duty = CNT_W'(du);
        it.delay = DELAY_W'(dl);
        it.data = $urandom;
        return it;
    endfunction

    function automatic t_cfg make_cfg(int ip, int ii, int inc, int sh,
                                      int op, int oi, int oinc, int osh);
        t_cfg c;
        c.inner_period = CNT_W'(ip);
        c.inner_iterations = CNT_W'(ii);
        c.inner_increment = STEP_W'(inc);
        c.inner_shift = STEP_W'(sh);
        c.outer_period = CNT_W'(op);
        c.outer_iterations = CNT_W'(oi);
        c.outer_increment = STEP_W'(oinc);
        c.outer_shift = STEP_W'(osh);
        return c;
    endfunction

    // Offer one item and hold it until accepted. Valid is left high so the
    // next item can follow back to back; gaps lower it explicitly.
    task automatic send_item(t_gen_item it);
        i_in_valid     <= 1'b1;
        i_cmd          <= it.cmd;
        i_start_addr   <= it.start_addr;
        i_duty         <= it.duty;
        i_delay_cycles <= it.delay;
        i_data_in      <= it.data;
        do @(posedge i_clk); while (!o_in_ready);
        pending_writes.push_back(predict_write(it));
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // Sender pauses until every expected write has come back.
    task automatic drain_writes();
        i_in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Registers are only touched with the pipe empty.
    task automatic load_config(t_cfg c);
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] val;
        drain_writes();
        for (int k = 0; k < 8; k++) begin
            idx = t_cfg_idx'(k);
            case (idx)
                CFG_INNER_PERIOD:     val = CFG_DATA_W'(c.inner_period);
                CFG_INNER_ITERATIONS: val = CFG_DATA_W'(c.inner_iterations);
                CFG_INNER_INCREMENT:  val = c.inner_increment;
                CFG_INNER_SHIFT:      val = c.inner_shift;
                CFG_OUTER_PERIOD:     val = CFG_DATA_W'(c.outer_period);
                CFG_OUTER_ITERATIONS: val = CFG_DATA_W'(c.outer_iterations);
                CFG_OUTER_INCREMENT:  val = c.outer_increment;
                default:              val = c.outer_shift;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cfg_shadow = c;
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready with random stall bursts, plus requested long holds
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (sink_hold_req != 0) begin
            i_out_ready   <= 1'b0;
            hold_left     <= sink_hold_req - 1;
            sink_hold_req = 0;
        end else if (sink_stalls_on && $urandom_range(0, 9) == 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= $urandom_range(0, 16);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(string what, t_write_req want, t_write_req got);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t %s: expected valid=%0b addr=%0d data=%h done=%0b",
                     $time, what, want.wr_valid, want.addr, want.data, want.done);
            $display("%0t %s:      got valid=%0b addr=%0d data=%h done=%0b",
                     $time, what, got.wr_valid, got.addr, got.data, got.done);
        end
    endtask

    // Result monitor: every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_write_req want;
        t_write_req got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_write_valid, o_write_addr, o_write_data, o_run_done};
            if (pending_writes.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_writes.pop_front();
                if (got.wr_valid !== want.wr_valid || got.addr !== want.addr ||
                    got.data !== want.data || got.done !== want.done)
                    report_mismatch("write mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset the block is idle with all configuration registers zero: ticks only
    // report done, and a start with zero iterations finishes on its first tick.
    task automatic test_idle_after_reset();
        send_item(tick_item(32'h7FFF_FFFF));
        send_item(start_item(0, 0, 0));
        send_item(tick_item(32'h8000_0000));
    endtask

    // Two-level nest with full duty, a short delay, address wrap at the top of
    // the bank, and one tick after done.
    task automatic test_two_level_run();
        load_config(make_cfg(3, 2, 1023, -1024, 0, 0, 0, 0));
        send_item(start_item(1023, 0, 1));
        send_item(tick_item(32'hFFFF_FFFF));             // delay running
        send_item(tick_item(32'h0000_0000));
        send_item(tick_item(32'hA5A5_A5A5));
        send_item(tick_item(32'h5A5A_5A5A));
        send_item(tick_item($urandom));
        send_item(tick_item($urandom));
        send_item(tick_item($urandom));
        send_item(tick_item($urandom));                  // after done
    endtask

    // Four-level nest, one active tick per period, extreme outer steps.
    task automatic test_four_level_duty();
        load_config(make_cfg(2, 1, -1, 5, 2, 2, -1024, 1023));
        send_item(start_item(0, 1, 0));
        repeat (8) send_item(tick_item($urandom));
    endtask

    // Period shrunk below the running tick count: the counter is past its
    // limit and the run stalls without writing until the next start.
    task automatic test_stale_limits();
        load_config(make_cfg(6, 3, 1, 0, 0, 0, 0, 0));
        send_item(start_item(100, 0, 0));
        repeat (3) send_item(tick_item($urandom));
        load_config(make_cfg(2, 3, 1, 0, 0, 0, 0, 0));
        send_item(tick_item($urandom));
        send_item(start_item(200, 0, 0));
        repeat (2) send_item(tick_item($urandom));
    endtask

    // Mostly well-formed runs with random content; some cut short by a new
    // start, some followed by stray ticks after done.
    task automatic play_random_runs(int unsigned n_items);
        int unsigned sent;
        int unsigned span;
        int unsigned ip, ii, op, oi, du, dl;
        t_cfg        c;
        sent = 0;
        while (sent < n_items) begin
            ip = $urandom_range(0, 4);
            ii = $urandom_range(0, 3);
            op = 0;
            oi = 0;
            if ($urandom_range(0, 1) == 1) begin
                op = $urandom_range(0, 2);
                oi = $urandom_range(0, 2);
            end
            c = make_cfg(ip, ii, $urandom_range(0, 2047), $urandom_range(0, 2047),
                         op, oi, $urandom_range(0, 2047), $urandom_range(0, 2047));
            load_config(c);
            repeat ($urandom_range(1, 3)) begin
                dl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
                case ($urandom_range(0, 2))
                    0:       du = 0;
                    1:       du = $urandom_range(1, ip + 1);
                    default: du = $urandom_range(0, 1023);
                endcase
                send_item(start_item($urandom_range(0, 1023), du, dl));
                span = dl + (ip + 1) * (ii + 1) * (op + 1) * (oi + 1) + $urandom_range(0, 3);
                if ($urandom_range(0, 4) == 0)
                    span = $urandom_range(1, span);
                repeat (span) send_item(tick_item($urandom));
                sent += span + 1;
            end
            // stray ticks once the run is over
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) send_item(tick_item($urandom));
        end
    endtask

    task automatic test_random_runs();
        play_random_runs(500);
    endtask

    // Register extremes, and the longest start delay.
    task automatic test_extreme_settings();
        load_config(make_cfg(1023, 1023, 1023, -1024, 1023, 1023, 1023, -1024));
        send_item(start_item(1023, 1023, 0));
        repeat (30) send_item(tick_item($urandom));
        load_config(make_cfg(0, 1023, -1024, 1023, 0, 0, -1024, 1023));
        send_item(start_item(0, 0, 3));
        repeat (20) send_item(tick_item($urandom));
        load_config(make_cfg(2, 2, -1, 1, 0, 0, 0, 0));
        send_item(start_item(512, 1, 255));
        repeat (262) send_item(tick_item($urandom));
    endtask

    // Output held off for a long stretch while items keep coming back to back,
    // so the pipe fills and input ready drops; then the sender waits it out.
    task automatic test_output_backpressure();
        bit gaps_saved;
        gaps_saved = src_gaps_on;
        load_config(make_cfg(3, 4, 1, 0, 0, 0, 0, 0));
        src_gaps_on = 1'b0;
        sink_hold_req = 64;
        send_item(start_item($urandom_range(0, 1023), 2, 0));
        repeat (40) send_item(tick_item($urandom));
        drain_writes();
        src_gaps_on = gaps_saved;
    endtask

    // Last stretch at full rate: no idling on either side.
    task automatic test_steady_stream();
        src_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        play_random_runs(150);
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_after_reset();
        test_two_level_run();
        test_four_level_duty();
        test_stale_limits();
        test_random_runs();
        test_output_backpressure();
        test_extreme_settings();
        test_steady_stream();
        drain_writes();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog: a hang or a lost result ends here.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

endmodule : testbench
